>>> rtl/plt_pkg.sv
// Shared types and constants for the preemptive LIFO task completion block.
package plt_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int ID_W    = 10;
   localparam int START_W = 11;
   localparam int DUR_W   = 10;
   localparam int END_W   = 12;
   localparam int DIFF_W  = 13;

   localparam logic OP_TASK  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic               operation;
      logic [ID_W-1:0]    task_id;
      logic [START_W-1:0] start_minute;
      logic [DUR_W-1:0]   duration;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] done_task_id;
      logic            last;
      logic            overflowed;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [DUR_W-1:0] rem;
   } stack_entry_type;

   localparam int ENTRY_W = $bits(stack_entry_type);

endpackage

>>> rtl/plt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module plt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/preemptive_lifo_task_completion.sv
// Top level of the preemptive LIFO task completion block.
//
// Input channel req_*: one transaction is a new task (id, start minute,
// duration) or a flush. Tasks are to come in nondecreasing start order (the
// block does not enforce it); a new task preempts a running one not yet ended,
// pushing it with its time left onto a RAM stack. Idle gaps finish stacked
// tasks, newest first. Result channel rsp_*: completed task ids in finishing
// order; last marks the final result of an input transaction, overflowed is
// the sticky flag set when a preempted task found the stack full and was
// dropped. For each stacked task read, the RAM read of the stack top is
// followed by a pop or an update; earlier results leave at the pops and the
// final result is registered in S_FIN. A task that causes no result leaves
// req_stall low; an empty flush holds it high for one cycle. req_stall is
// high while results of the previous transaction are still being produced.
// A stalled rsp_* holds its payload; one result waits in an output register
// and one in a hold register, and the sequencer waits while both are full.
// Reset clears the running task, the stack count and the overflow flag;
// stack RAM contents need no clearing.
module preemptive_lifo_task_completion (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  plt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output plt_pkg::rsp_type rsp_data
);

   import plt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [ID_W-1:0]  cur_id_ff, cur_id_in;
   logic [END_W-1:0] cur_end_ff, cur_end_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [START_W-1:0] gap_ff, gap_in;
   logic             drain_all_ff, drain_all_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [ID_W-1:0]  hold_id_ff, hold_id_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   stack_entry_type   ram_wdata, top;
   logic [ENTRY_W-1:0] ram_rdata;

   logic              req_fire, slot_free, take;
   logic [CNT_W-1:0]  count_dec;
   logic [ADDR_W-1:0] top_addr;
   logic [DIFF_W-1:0] diff, rem_raw;
   logic [DUR_W-1:0]  rem_sat;
   logic [START_W-1:0] gap_left;

   plt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign count_dec = count_ff - CNT_W'(1);
   assign top_addr  = count_dec[ADDR_W-1:0];
   assign top       = ram_rdata;

   assign diff    = {2'b00, req_data.start_minute} - {1'b0, cur_end_ff};
   assign rem_raw = -diff;
   assign rem_sat = (rem_raw > DIFF_W'(1023)) ? {DUR_W{1'b1}} : rem_raw[DUR_W-1:0];

   assign take     = drain_all_ff || ({1'b0, top.rem} <= gap_ff);
   assign gap_left = gap_ff - {1'b0, top.rem};

   always_comb begin
      state_in      = state_ff;
      cur_valid_in  = cur_valid_ff;
      cur_id_in     = cur_id_ff;
      cur_end_in    = cur_end_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      gap_in        = gap_ff;
      drain_all_in  = drain_all_ff;
      hold_valid_in = hold_valid_ff;
      hold_id_in    = hold_id_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = top_addr;
      ram_wdata     = top;
      ram_re        = 1'b0;
      ram_raddr     = top_addr;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.operation == OP_FLUSH) begin
                  hold_valid_in = cur_valid_ff;
                  hold_id_in    = cur_id_ff;
                  cur_valid_in  = 1'b0;
                  drain_all_in  = 1'b1;
                  state_in      = (count_ff != '0) ? S_READ : S_FIN;
               end else begin
                  drain_all_in = 1'b0;
                  if (cur_valid_ff) begin
                     if (!diff[DIFF_W-1]) begin
                        hold_valid_in = 1'b1;
                        hold_id_in    = cur_id_ff;
                        gap_in        = diff[START_W-1:0];
                        state_in      = (diff != '0 && count_ff != '0) ? S_READ : S_FIN;
                     end else if (count_ff < CNT_W'(STACK_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = count_ff[ADDR_W-1:0];
                        ram_wdata = '{id: cur_id_ff, rem: rem_sat};
                        count_in  = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  cur_valid_in = 1'b1;
                  cur_id_in    = req_data.task_id;
                  cur_end_in   = {1'b0, req_data.start_minute} + {2'b00, req_data.duration};
               end
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (take) begin
               if (!(hold_valid_ff && !slot_free)) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{done_task_id: hold_id_ff, last: 1'b0,
                                      overflowed: ovf_ff};
                  end
                  hold_valid_in = 1'b1;
                  hold_id_in    = top.id;
                  count_in      = count_dec;
                  if (!drain_all_ff) begin
                     gap_in = gap_left;
                  end
                  state_in = (count_ff != CNT_W'(1) && (drain_all_ff || gap_left != '0))
                           ? S_READ : S_FIN;
               end
            end else begin
               ram_we    = 1'b1;
               ram_wdata = '{id: top.id, rem: top.rem - gap_ff[DUR_W-1:0]};
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            if (hold_valid_ff) begin
               if (slot_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = '{done_task_id: hold_id_ff, last: 1'b1,
                                    overflowed: ovf_ff};
                  hold_valid_in = 1'b0;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_valid_ff  <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_valid_ff  <= cur_valid_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_id_ff    <= cur_id_in;
      cur_end_ff   <= cur_end_in;
      gap_ff       <= gap_in;
      drain_all_ff <= drain_all_in;
      hold_id_ff   <= hold_id_in;
      rsp_data_ff  <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !hold_valid_ff)
      else $error("pending result left behind at idle");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ || state_ff == S_POP) |-> count_ff != '0)
      else $error("stack read while empty");

   a_gap_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP && !drain_all_ff) |-> gap_ff != '0)
      else $error("drain step with no idle time");
`endif

endmodule

>>> bench/plt_completion_checker.sv
// Checker for the preemptive LIFO task completion block: predicts and compares completions.
module plt_completion_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  plt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  plt_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               outstanding
);

   import plt_pkg::*;

   logic               run_valid;
   logic [ID_W-1:0]    run_id;
   logic [END_W-1:0]   run_end;
   logic [ID_W-1:0]    held_id [STACK_DEPTH];
   logic [DUR_W-1:0]   held_rem [STACK_DEPTH];
   int unsigned        held_count;
   logic               drop_flag;
   rsp_type            completion_q [$];
   int                 errors = 0;

   // Apply one accepted transaction to the schedule and queue the completions it causes.
   task automatic advance_schedule(input req_type t);
      logic [ID_W-1:0] ids [$];
      int              gap;
      int unsigned     rem;
      rsp_type         r;
      if (t.operation == OP_FLUSH) begin
         if (run_valid)
            ids.insert(ids.size(), run_id);
         while (held_count > 0) begin
            held_count--;
            ids.insert(ids.size(), held_id[held_count]);
         end
         run_valid = 1'b0;
      end else begin
         if (run_valid) begin
            gap = int'(t.start_minute) - int'(run_end);
            if (gap >= 0) begin
               ids.insert(ids.size(), run_id);
               // idle minutes go to the most recently paused task first
               while (held_count > 0 && gap > 0) begin
                  if (int'(held_rem[held_count-1]) <= gap) begin
                     gap -= int'(held_rem[held_count-1]);
                     held_count--;
                     ids.insert(ids.size(), held_id[held_count]);
                  end else begin
                     held_rem[held_count-1] = held_rem[held_count-1] - DUR_W'(gap);
                     gap = 0;
                  end
               end
            end else begin
               rem = (-gap > 1023) ? 1023 : -gap;
               if (held_count < STACK_DEPTH) begin
                  held_id[held_count]  = run_id;
                  held_rem[held_count] = DUR_W'(rem);
                  held_count++;
               end else begin
                  drop_flag = 1'b1;
               end
            end
         end
         run_valid = 1'b1;
         run_id    = t.task_id;
         run_end   = END_W'(t.start_minute) + END_W'(t.duration);
      end
      foreach (ids[k]) begin
         r.done_task_id = ids[k];
         r.last         = (k == ids.size() - 1);
         r.overflowed   = drop_flag;
         completion_q.insert(completion_q.size(), r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         run_valid  = 1'b0;
         run_id     = '0;
         run_end    = '0;
         held_count = 0;
         drop_flag  = 1'b0;
         completion_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (completion_q.size() == 0) begin
               $display("%0t: unexpected completion transaction, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = completion_q[0];
               completion_q.delete(0);
               if (rsp_data.done_task_id !== want.done_task_id) begin
                  $display("%0t: done_task_id expected %0d actual %0d", $time,
                           want.done_task_id, rsp_data.done_task_id);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time,
                           want.last, rsp_data.last);
                  errors++;
               end
               if (rsp_data.overflowed !== want.overflowed) begin
                  $display("%0t: overflowed expected %0b actual %0b", $time,
                           want.overflowed, rsp_data.overflowed);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall)
            advance_schedule(req_data);
      end
      fail_count  <= errors;
      outstanding <= completion_q.size();
   end

endmodule

>>> bench/tb_preemptive_lifo_task_completion.sv
// Testbench top for the preemptive LIFO task completion block: stimulus and verdict.
module tb_preemptive_lifo_task_completion;

   import plt_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      fail_count;
   int      outstanding;

   bit      quiet    = 1'b0;
   bit      hold_rsp = 1'b0;
   int      day_minute = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   preemptive_lifo_task_completion i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   plt_completion_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   function automatic req_type task_item(int id, int start, int dur);
      req_type t;
      t.operation    = OP_TASK;
      t.task_id      = ID_W'(id);
      t.start_minute = START_W'(start);
      t.duration     = DUR_W'(dur);
      return t;
   endfunction

   function automatic req_type flush_item();
      req_type t;
      t.operation    = OP_FLUSH;
      t.task_id      = ID_W'($urandom);
      t.start_minute = START_W'($urandom);
      t.duration     = DUR_W'($urandom);
      return t;
   endfunction

   // Mostly ascending task starts with random gaps; some flushes and out-of-order noise.
   function automatic req_type random_item();
      req_type t;
      int      pick;
      pick = $urandom_range(0, 99);
      t = task_item($urandom, $urandom, ($urandom_range(0, 4) == 0) ? $urandom
                                                                    : $urandom_range(0, 60));
      if (pick < 6 || day_minute > 2000) begin
         t = flush_item();
         day_minute = $urandom_range(0, 300);
      end else if (pick >= 12) begin
         day_minute += $urandom_range(0, 40);
         t.start_minute = START_W'(day_minute);
      end
      return t;
   endfunction

   task automatic offer(input req_type item);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      @(posedge clock);
   endtask

   initial begin
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_data  <= '0;
      reset     <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty flush, zero duration, exact finish, nesting, saturation
      offer(flush_item());
      offer(task_item(0, 0, 0));
      offer(task_item(1023, 0, 1023));
      offer(task_item(5, 10, 100));
      offer(task_item(6, 20, 30));
      offer(task_item(7, 50, 5));
      offer(task_item(8, 200, 10));
      offer(task_item(9, 2047, 1023));
      offer(task_item(10, 100, 1));
      offer(task_item(11, 0, 2));
      offer(flush_item());
      offer(flush_item());
      offer(task_item(512, 1439, 1));
      offer(task_item(341, 1439, 0));
      offer(task_item(682, 1440, 7));
      offer(task_item(1, 1440, 3));
      offer(flush_item());

      for (int n = 0; n < 155; n++) begin
         if (n == 50)
            hold_rsp = 1'b1;
         if (n == 100)
            settle();
         if (n == 130)
            quiet = 1'b1;
         offer(random_item());
      end

      // fill the stack past its depth; the flush then returns the longest burst
      settle();
      offer(flush_item());
      for (int k = 0; k < STACK_DEPTH + 2; k++)
         offer(task_item(100 + k, 100, 500));
      offer(flush_item());
      offer(task_item(77, 5, 1));
      offer(flush_item());

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("preemptive_lifo_task_completion test passed");
      else
         $display("preemptive_lifo_task_completion test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("preemptive_lifo_task_completion test failed");
      $finish;
   end

endmodule
